### design/hsv2rgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types, constants and the hue fraction table shared by the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Hue handling. The offset is a multiple of 360 large enough to make any
  // 16-bit signed hue non-negative.
  localparam logic [16:0] HUE_OFFSET = 17'd33120;
  localparam logic [16:0] HUE_RANGE  = 17'd360;
  localparam int          SECTOR_DEG = 60;

  // floor(x / 360) == (x * RECIP_M) >> RECIP_SH, exact for x below 74898.
  localparam logic [15:0] RECIP_M  = 16'd46604;
  localparam int          RECIP_SH = 24;

  // Unsigned Q0.16 one.
  localparam logic [16:0] F16_ONE = 17'h10000;

  // Colour sectors of 60 degrees each.
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_t;

  typedef logic [15:0] frac_tbl_t [SECTOR_DEG];

  // floor(r * 65536 / 60) for every remainder within a sector.
  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int i = 0; i < SECTOR_DEG; i++) begin
      t[i] = 16'((i * 65536) / SECTOR_DEG);
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

endpackage
`default_nettype wire

### design/hsv2rgb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_in_if
// Valid/ready channel carrying one HSV colour item.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue_degrees;
  logic signed [9:0]  saturation;
  logic signed [9:0]  brightness;

  modport source (output valid, output hue_degrees, output saturation,
                  output brightness, input ready);
  modport sink   (input valid, input hue_degrees, input saturation,
                  input brightness, output ready);
endinterface
`default_nettype wire

### design/hsv2rgb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_out_if
// Valid/ready channel carrying one 8-bit RGB item.
// ----------------------------------------------------------------------------
interface hsv2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface
`default_nettype wire

### design/hsv2rgb_hue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_hue
// Four-stage hue path: reduction modulo 360, then sector and Q0.16 fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_hue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 valid_i,
  input  wire logic [15:0]          hue_i,
  output logic                      valid_o,
  output hsv2rgb_pkg::sector_t      sector_o,
  output logic [15:0]               frac_o
);
  import hsv2rgb_pkg::*;

  logic [3:0]  valid_r;
  logic [16:0] ofs_r;
  logic [16:0] ofs2_r;
  logic [7:0]  quot_r;
  logic [8:0]  hmod_r;
  sector_t     sector_r;
  logic [15:0] frac_r;

  logic [16:0] ofs_nxt;
  logic [32:0] recip_prod;
  logic [16:0] rem_raw;
  logic [8:0]  hmod_nxt;
  sector_t     sector_nxt;
  logic [8:0]  sect_base;
  logic [5:0]  rem60;

  // Sign-extend and add a multiple of 360; the true sum is always positive.
  assign ofs_nxt    = {hue_i[15], hue_i} + HUE_OFFSET;
  assign recip_prod = 33'(ofs_r) * 33'(RECIP_M);

  always_comb begin
    rem_raw = ofs2_r - 17'(17'(quot_r) * HUE_RANGE);
    if (rem_raw >= HUE_RANGE) begin
      rem_raw = rem_raw - HUE_RANGE;
    end
    hmod_nxt = 9'(rem_raw);
  end

  always_comb begin
    if (hmod_r < 9'd60) begin
      sector_nxt = SECT_RY;
      sect_base  = 9'd0;
    end else if (hmod_r < 9'd120) begin
      sector_nxt = SECT_YG;
      sect_base  = 9'd60;
    end else if (hmod_r < 9'd180) begin
      sector_nxt = SECT_GC;
      sect_base  = 9'd120;
    end else if (hmod_r < 9'd240) begin
      sector_nxt = SECT_CB;
      sect_base  = 9'd180;
    end else if (hmod_r < 9'd300) begin
      sector_nxt = SECT_BM;
      sect_base  = 9'd240;
    end else begin
      sector_nxt = SECT_MR;
      sect_base  = 9'd300;
    end
    rem60 = 6'(hmod_r - sect_base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ofs_r    <= ofs_nxt;
      ofs2_r   <= ofs_r;
      quot_r   <= recip_prod[RECIP_SH +: 8];
      hmod_r   <= hmod_nxt;
      sector_r <= sector_nxt;
      frac_r   <= FRAC_TBL[rem60];
    end
  end

  assign valid_o  = valid_r[3];
  assign sector_o = sector_r;
  assign frac_o   = frac_r;

endmodule
`default_nettype wire

### design/hsv2rgb_chan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// Five-stage arithmetic for the v, p, q and t channels, scaled by 255.
// ----------------------------------------------------------------------------
module hsv2rgb_chan #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 valid_i,
  input  wire hsv2rgb_pkg::sector_t sector_i,
  input  wire logic [15:0]          frac_i,
  input  wire logic [FRAC_BITS:0]   sat_i,
  input  wire logic [FRAC_BITS:0]   val_i,
  output logic                      valid_o,
  output hsv2rgb_pkg::sector_t      sector_o,
  output logic [7:0]                cv_o,
  output logic [7:0]                cp_o,
  output logic [7:0]                cq_o,
  output logic [7:0]                ct_o
);
  import hsv2rgb_pkg::*;

  localparam int SW  = FRAC_BITS + 1;       // clamped s and v
  localparam int PW  = 2 * FRAC_BITS + 1;   // p numerator
  localparam int AW  = FRAC_BITS + 17;      // s*f and 1 - s*f
  localparam int HW  = AW - 16;             // upper slice of 1 - s*f
  localparam int NW  = 2 * FRAC_BITS + 17;  // q and t numerators
  localparam int SC2 = 2 * FRAC_BITS;
  localparam int SC3 = 2 * FRAC_BITS + 16;
  localparam logic [SW-1:0] ONE    = SW'(1) << FRAC_BITS;
  localparam logic [AW-1:0] ONE_SH = AW'(1) << (FRAC_BITS + 16);

  logic [4:0]        valid_r;
  sector_t           sector_r [5];
  logic [SW-1:0]     val_r    [4];
  logic [PW-1:0]     pn_r     [4];
  logic [AW-1:0]     sf_r;
  logic [AW-1:0]     sfc_r;
  logic [AW-1:0]     qa_r;
  logic [AW-1:0]     ta_r;
  logic [SW+15:0]    qlo_r;
  logic [SW+HW-1:0]  qhi_r;
  logic [SW+15:0]    tlo_r;
  logic [SW+HW-1:0]  thi_r;
  logic [NW-1:0]     qn_r;
  logic [NW-1:0]     tn_r;
  logic [7:0]        cv_r;
  logic [7:0]        cp_r;
  logic [7:0]        cq_r;
  logic [7:0]        ct_r;

  logic [16:0]       frac_c;
  logic [NW+7:0]     qm;
  logic [NW+7:0]     tm;
  logic [PW+7:0]     pm;
  logic [SW+7:0]     vm;

  assign frac_c = F16_ONE - {1'b0, frac_i};

  // x * 255 as (x << 8) - x before the final truncating shift.
  assign qm = {qn_r, 8'd0} - (NW+8)'(qn_r);
  assign tm = {tn_r, 8'd0} - (NW+8)'(tn_r);
  assign pm = {pn_r[3], 8'd0} - (PW+8)'(pn_r[3]);
  assign vm = {val_r[3], 8'd0} - (SW+8)'(val_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage A: products with s.
      sf_r        <= AW'(AW'(sat_i) * AW'(frac_i));
      sfc_r       <= AW'(AW'(sat_i) * AW'(frac_c));
      pn_r[0]     <= PW'(PW'(val_i) * PW'(ONE - sat_i));
      val_r[0]    <= val_i;
      sector_r[0] <= sector_i;
      // Stage B: complements.
      qa_r        <= ONE_SH - sf_r;
      ta_r        <= ONE_SH - sfc_r;
      pn_r[1]     <= pn_r[0];
      val_r[1]    <= val_r[0];
      sector_r[1] <= sector_r[0];
      // Stage C: partial products of v with the complements.
      qlo_r       <= (SW+16)'(val_r[1]) * (SW+16)'(qa_r[15:0]);
      qhi_r       <= (SW+HW)'(val_r[1]) * (SW+HW)'(qa_r[AW-1:16]);
      tlo_r       <= (SW+16)'(val_r[1]) * (SW+16)'(ta_r[15:0]);
      thi_r       <= (SW+HW)'(val_r[1]) * (SW+HW)'(ta_r[AW-1:16]);
      pn_r[2]     <= pn_r[1];
      val_r[2]    <= val_r[1];
      sector_r[2] <= sector_r[1];
      // Stage D: recombine the partial products.
      qn_r        <= NW'({qhi_r, 16'd0}) + NW'(qlo_r);
      tn_r        <= NW'({thi_r, 16'd0}) + NW'(tlo_r);
      pn_r[3]     <= pn_r[2];
      val_r[3]    <= val_r[2];
      sector_r[3] <= sector_r[2];
      // Stage E: scale to 0..255.
      cq_r        <= qm[SC3 +: 8];
      ct_r        <= tm[SC3 +: 8];
      cp_r        <= pm[SC2 +: 8];
      cv_r        <= vm[FRAC_BITS +: 8];
      sector_r[4] <= sector_r[3];
    end
  end

  assign valid_o  = valid_r[4];
  assign sector_o = sector_r[4];
  assign cv_o     = cv_r;
  assign cp_o     = cp_r;
  assign cq_o     = cq_r;
  assign ct_o     = ct_r;

endmodule
`default_nettype wire

### design/hsv_to_rgb_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined conversion of a signed HSV colour to 8-bit RGB.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Fields                                  Width
//   in_chan   sink       hue_degrees, saturation, brightness     16s,10s,10s
//   out_chan  source     red, green, blue                        8,8,8
//
// One item is accepted per clock cycle while the output is not stalled; each
// item passes through four stages of hue reduction, five of channel
// arithmetic and the output register. The whole pipeline advances together;
// while a finished item waits on the output, every stage holds and
// in_chan.ready is low, so nothing is lost or repeated. Reset clears the
// valid bits only; the data registers are not reset.
//
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  hsv2rgb_in_if.sink   in_chan,
  hsv2rgb_out_if.source out_chan
);
  import hsv2rgb_pkg::*;

  localparam int SW  = FRAC_BITS + 1;
  localparam int ONE = 1 << FRAC_BITS;

  // The pipeline moves whenever the output register is empty or being read.
  logic          en;
  logic [SW-1:0] sat_clamp;
  logic [SW-1:0] val_clamp;
  logic [SW-1:0] sat_r [4];
  logic [SW-1:0] val_r [4];

  logic          hue_valid;
  sector_t       hue_sector;
  logic [15:0]   hue_frac;

  logic          chan_valid;
  sector_t       chan_sector;
  logic [7:0]    cv;
  logic [7:0]    cp;
  logic [7:0]    cq;
  logic [7:0]    ct;

  logic          out_valid_r;
  logic [7:0]    red_r;
  logic [7:0]    green_r;
  logic [7:0]    blue_r;
  logic [7:0]    red_nxt;
  logic [7:0]    green_nxt;
  logic [7:0]    blue_nxt;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // Saturation and value are clamped to the range zero to one.
  always_comb begin
    if (in_chan.saturation[9]) begin
      sat_clamp = '0;
    end else if (32'(in_chan.saturation[8:0]) > 32'(ONE)) begin
      sat_clamp = SW'(ONE);
    end else begin
      sat_clamp = SW'(in_chan.saturation[8:0]);
    end
    if (in_chan.brightness[9]) begin
      val_clamp = '0;
    end else if (32'(in_chan.brightness[8:0]) > 32'(ONE)) begin
      val_clamp = SW'(ONE);
    end else begin
      val_clamp = SW'(in_chan.brightness[8:0]);
    end
  end

  // s and v wait here while the hue path works out sector and fraction.
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= sat_clamp;
      val_r[0] <= val_clamp;
      for (int i = 1; i < 4; i++) begin
        sat_r[i] <= sat_r[i-1];
        val_r[i] <= val_r[i-1];
      end
    end
  end

  hsv2rgb_hue u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (in_chan.valid),
    .hue_i    (in_chan.hue_degrees),
    .valid_o  (hue_valid),
    .sector_o (hue_sector),
    .frac_o   (hue_frac)
  );

  hsv2rgb_chan #(
    .FRAC_BITS (FRAC_BITS)
  ) u_chan (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (hue_valid),
    .sector_i (hue_sector),
    .frac_i   (hue_frac),
    .sat_i    (sat_r[3]),
    .val_i    (val_r[3]),
    .valid_o  (chan_valid),
    .sector_o (chan_sector),
    .cv_o     (cv),
    .cp_o     (cp),
    .cq_o     (cq),
    .ct_o     (ct)
  );

  // Channel order by sector; the first sector also covers unused codes.
  always_comb begin
    case (chan_sector)
      SECT_YG: begin
        red_nxt = cq; green_nxt = cv; blue_nxt = cp;
      end
      SECT_GC: begin
        red_nxt = cp; green_nxt = cv; blue_nxt = ct;
      end
      SECT_CB: begin
        red_nxt = cp; green_nxt = cq; blue_nxt = cv;
      end
      SECT_BM: begin
        red_nxt = ct; green_nxt = cp; blue_nxt = cv;
      end
      SECT_MR: begin
        red_nxt = cv; green_nxt = cp; blue_nxt = cq;
      end
      default: begin
        red_nxt = cv; green_nxt = ct; blue_nxt = cp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;

`ifndef ASSERT_OFF
  // A waiting result must hold the whole pipeline, input side included.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while a result is stalled");

  // A new result only appears when the channel stage held a valid item.
  a_out_from_chan : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(chan_valid))
    else $error("result appeared without a valid item behind it");

  // A stalled result keeps its colour until it is taken.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=>
      ($stable(red_r) && $stable(green_r) && $stable(blue_r) && out_valid_r))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

### tb/sv/hsv_to_rgb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both channels of the HSV to RGB converter. It works out the RGB
// colour that each accepted HSV item should produce and compares every
// delivered result, field by field, with the oldest colour still awaited.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  hsv2rgb_in_if  in_mon,
  hsv2rgb_out_if out_mon,
  output int     mismatches,
  output int     results_seen,
  output int     awaiting
);
  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t rgb_awaited [$];

  // Saturation and value are limited to the range 0.0 to 1.0.
  function automatic longint unsigned clamp_unit(logic signed [9:0] x);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (x < 0) return 0;
    if (longint'(x) > one) return one;
    return longint'(x);
  endfunction

  function automatic rgb_t convert_colour(logic signed [15:0] hue,
                                          logic signed [9:0]  sat,
                                          logic signed [9:0]  bri);
    longint unsigned one, s, v, f;
    longint unsigned p_num, q_num, t_num;
    longint unsigned c_v, c_p, c_q, c_t;
    int              h;
    int              rem;
    sector_t         sect;
    rgb_t            res;
    one = longint'(1) << FRAC_BITS;
    s   = clamp_unit(sat);
    v   = clamp_unit(bri);
    // Bring the hue into 0..359; the remainder keeps the dividend's sign.
    h = int'(hue) % int'(HUE_RANGE);
    if (h < 0) h += int'(HUE_RANGE);
    sect = sector_t'(h / SECTOR_DEG);
    rem  = h % SECTOR_DEG;
    f    = (longint'(rem) * longint'(F16_ONE)) / SECTOR_DEG;
    p_num = v * (one - s);
    q_num = v * ((one << 16) - s * f);
    t_num = v * ((one << 16) - s * (longint'(F16_ONE) - f));
    c_v = (v * 255) >> FRAC_BITS;
    c_p = (p_num * 255) >> (2 * FRAC_BITS);
    c_q = (q_num * 255) >> (2 * FRAC_BITS + 16);
    c_t = (t_num * 255) >> (2 * FRAC_BITS + 16);
    case (sect)
      SECT_YG: res = '{red: 8'(c_q), green: 8'(c_v), blue: 8'(c_p)};
      SECT_GC: res = '{red: 8'(c_p), green: 8'(c_v), blue: 8'(c_t)};
      SECT_CB: res = '{red: 8'(c_p), green: 8'(c_q), blue: 8'(c_v)};
      SECT_BM: res = '{red: 8'(c_t), green: 8'(c_p), blue: 8'(c_v)};
      SECT_MR: res = '{red: 8'(c_v), green: 8'(c_p), blue: 8'(c_q)};
      default: res = '{red: 8'(c_v), green: 8'(c_t), blue: 8'(c_p)};
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rgb_t want;
    if (rst_n) begin
      // Results are compared before new colours are queued; the pipeline
      // is deep enough that an item never meets its own result here.
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (rgb_awaited.size() == 0) begin
          $error("RGB result %0d/%0d/%0d arrived with no colour outstanding",
                 out_mon.red, out_mon.green, out_mon.blue);
          mismatches++;
        end else begin
          want = rgb_awaited.pop_front();
          if (out_mon.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_mon.red);
            mismatches++;
          end
          if (out_mon.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_mon.green);
            mismatches++;
          end
          if (out_mon.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_mon.blue);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        rgb_awaited = {rgb_awaited, convert_colour(in_mon.hue_degrees,
                                                   in_mon.saturation,
                                                   in_mon.brightness)};
      end
      awaiting = rgb_awaited.size();
    end
  end

endmodule

### tb/sv/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Regression for the HSV to RGB converter. A short directed set covers every
// hue sector, hue wrap-around in both directions and the clamping of
// saturation and value; a long random set follows. Both channels idle at
// random, and the result side once holds off long enough to back the whole
// pipeline up. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

  localparam int FRAC_BITS    = 8;
  localparam int UNIT_ONE     = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 500;
  // The calm tail of the run, in items, during which nobody idles.
  localparam int CALM_ITEMS   = 100;
  // Long result-side hold-off, well beyond the depth of the pipeline.
  localparam int LONG_HOLD    = 400;
  // Drain after the last expected result, well beyond the pipeline depth.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n = 1'b0;

  hsv2rgb_in_if  in_chan ();
  hsv2rgb_out_if out_chan ();

  int  mismatches;
  int  results_seen;
  int  awaiting;
  int  colours_sent;
  int  directed_sent;
  int  cycles;
  int  gap_pct;

  // Set by the stimulus side: the tail of the run goes without idling, and
  // once during the random part the result side is asked for a long hold.
  bit  quiet_tail;
  bit  hold_out;

  hsv_to_rgb_converter #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  hsv_to_rgb_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) colour_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .awaiting     (awaiting)
  );

  // Free-running clock with a period of 10 ns.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Synchronous reset, asserted at the start and never again.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Offers one HSV item and waits until the block takes it. Afterwards the
  // sender may go quiet for a random burst, so that gaps land on every
  // stage of the pipeline.
  task automatic send_colour(input logic signed [15:0] hue,
                             input logic signed [9:0]  sat,
                             input logic signed [9:0]  bri);
    in_chan.valid       <= 1'b1;
    in_chan.hue_degrees <= hue;
    in_chan.saturation  <= sat;
    in_chan.brightness  <= bri;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    colours_sent++;
    if (!quiet_tail && !hold_out && $urandom_range(1, 100) <= gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Saturation and value near the interesting points: both ends of the
  // field and either side of zero and of one.
  function automatic logic signed [9:0] pick_unit_edge();
    case ($urandom_range(0, 7))
      0:       return -10'sd512;
      1:       return -10'sd1;
      2:       return 10'sd0;
      3:       return 10'sd1;
      4:       return 10'(UNIT_ONE - 1);
      5:       return 10'(UNIT_ONE);
      6:       return 10'(UNIT_ONE + 1);
      default: return 10'sd511;
    endcase
  endfunction

  // Stimulus: directed colours first, then the random set.
  initial begin : hsv_source
    logic signed [15:0] hue;
    logic signed [9:0]  sat;
    logic signed [9:0]  bri;
    in_chan.valid       <= 1'b0;
    in_chan.hue_degrees <= '0;
    in_chan.saturation  <= '0;
    in_chan.brightness  <= '0;
    gap_pct = 0;
    wait (rst_n);
    @(posedge clk);

    // Hue 0, then one colour in the middle of each of the six sectors.
    send_colour(16'sd0,   10'sd256, 10'sd256);
    send_colour(16'sd30,  10'sd256, 10'sd256);
    send_colour(16'sd90,  10'sd256, 10'sd256);
    send_colour(16'sd150, 10'sd200, 10'sd256);
    send_colour(16'sd210, 10'sd128, 10'sd200);
    send_colour(16'sd270, 10'sd64,  10'sd100);
    send_colour(16'sd330, 10'sd256, 10'sd255);
    // Sector boundaries and hue wrap-around, upwards and downwards.
    send_colour(16'sd359, 10'sd256, 10'sd256);
    send_colour(16'sd360, 10'sd256, 10'sd256);
    send_colour(16'sd59,  10'sd256, 10'sd256);
    send_colour(16'sd60,  10'sd256, 10'sd256);
    send_colour(-16'sd1,  10'sd256, 10'sd256);
    send_colour(-16'sd360, 10'sd200, 10'sd200);
    send_colour(-16'sd300, 10'sd1,   10'sd511);
    // The extremes of the hue field.
    send_colour(-16'sd32768, 10'sd256, 10'sd256);
    send_colour(16'sd32767,  10'sd256, 10'sd256);
    // Saturation below zero and above one, then value the same way.
    send_colour(16'sd120, -10'sd512, 10'sd256);
    send_colour(16'sd240, -10'sd1,   10'sd256);
    send_colour(16'sd300, 10'sd257,  10'sd256);
    send_colour(16'sd45,  10'sd511,  10'sd511);
    send_colour(16'sd45,  10'sd256,  -10'sd1);
    send_colour(16'sd200, 10'sd256,  -10'sd512);
    // Black, and just short of full scale.
    send_colour(16'sd100, 10'sd0,    10'sd0);
    send_colour(16'sd15,  10'sd255,  10'sd255);
    directed_sent = colours_sent;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Sender idling changes character every 32 items, so there are
      // stretches with no gaps at all as well as busy and sparse ones.
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (n == 150) hold_out = 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) quiet_tail = 1'b1;
      case ($urandom_range(0, 3))
        0: begin
          // Anything the fields can hold.
          hue = 16'($urandom);
          sat = 10'($urandom);
          bri = 10'($urandom);
        end
        1: begin
          // Ordinary colours, already in range.
          hue = 16'($urandom_range(0, 359));
          sat = 10'($urandom_range(0, UNIT_ONE));
          bri = 10'($urandom_range(0, UNIT_ONE));
        end
        2: begin
          // Hue on or beside a sector boundary anywhere in the field, with
          // saturation and value at their edges.
          hue = 16'(60 * (int'($urandom_range(0, 1092)) - 546)
                    + int'($urandom_range(0, 2)) - 1);
          sat = pick_unit_edge();
          bri = pick_unit_edge();
        end
        default: begin
          // Any hue with an in-range colour.
          hue = 16'($urandom);
          sat = 10'($urandom_range(0, UNIT_ONE));
          bri = 10'($urandom_range(0, UNIT_ONE));
        end
      endcase
      send_colour(hue, sat, bri);
    end
    in_chan.valid <= 1'b0;
  end

  // Result side: ready in stretches of 64 attempts with a varying chance of
  // stalling, plus the one long hold-off the stimulus asks for. While it
  // lasts the sender keeps offering, so the pipeline fills and the block
  // has to hold its input off.
  initial begin : rgb_sink
    int stretch_left;
    int stall_pct;
    stretch_left = 0;
    stall_pct    = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stretch_left == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
        stretch_left = 64;
      end
      stretch_left--;
      if (hold_out) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else if (!quiet_tail && $urandom_range(1, 100) <= stall_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d colours still awaited",
             cycles, awaiting);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Verdict: once every item has gone in and every expected colour has come
  // back, wait out the pipeline depth so that any stray extra result shows.
  initial begin : verdict
    wait (rst_n);
    wait (colours_sent == directed_sent + RANDOM_ITEMS && directed_sent > 0);
    wait (awaiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d HSV colours (%0d directed, %0d random) over all six sectors,",
             colours_sent, directed_sent, colours_sent - directed_sent);
    $display("with hue wrap-around, clamping and a full pipeline stall; %0d RGB results checked.",
             results_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
